@@ src/eeprom_page_write_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// EEPROM page-write sequencer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef EEPROM_PAGE_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define EEPROM_PAGE_WRITE_SEQUENCER_CORE_ASSERT_SVH

// Checked only outside reset
`define EPWS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define EPWS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/epws_pkg.sv @@
// ----------------------------------------------------------------------------
// EEPROM page-write sequencer package
// Item types, codes and page geometry shared by the sequencer modules.
// ----------------------------------------------------------------------------
package epws_pkg;

  // Page geometry (power of two)
  localparam int PageBytes = 64;
  localparam int OffW      = $clog2(PageBytes);
  localparam int ChunkW    = $clog2(PageBytes + 1);

  localparam logic [15:0] MaxWriteAddr = 16'h7FFF;
  localparam logic [7:0]  DevCmd       = 8'hA0;

  typedef enum logic [2:0] {
    FUNC_READ    = 3'd0,
    FUNC_WRITE   = 3'd1,
    FUNC_DONE    = 3'd2,
    FUNC_TICK    = 3'd3,
    FUNC_REFUSED = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_POLL  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  chip_select;
    logic [15:0] mem_address;
    logic [15:0] length;
    logic        want_notify;
    logic        trx_ok;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  issue;
    logic [7:0]  device_byte;
    logic [15:0] trx_address;
    logic [15:0] trx_count;
    logic [15:0] buffer_offset;
    logic        notify;
    logic        notify_ok;
    logic [2:0]  ctrl_state;
  } out_item_t;

  // Chunk planner result
  typedef struct packed {
    logic              empty;
    logic [ChunkW-1:0] size;
  } chunk_t;

endpackage

@@ src/epws_chunk.sv @@
// ----------------------------------------------------------------------------
// EEPROM page-write chunk planner
// Sizes the next write chunk: at most one page, never across a page boundary.
// ----------------------------------------------------------------------------
module epws_chunk import epws_pkg::*; (
  input  logic [15:0] bytes_left_i,
  input  logic [15:0] address_i,
  output chunk_t      chunk_o
);

  logic [ChunkW-1:0] full_n;
  logic [ChunkW-1:0] room;

  // Clamp remaining bytes to one page
  assign full_n = (bytes_left_i > 16'(PageBytes)) ? ChunkW'(PageBytes)
                                                  : bytes_left_i[ChunkW-1:0];

  // Bytes left before the page boundary
  assign room = ChunkW'(PageBytes) - ChunkW'(address_i[OffW-1:0]);

  assign chunk_o.empty = (bytes_left_i == 16'd0);
  assign chunk_o.size  = (full_n > room) ? room : full_n;

endmodule

@@ src/eeprom_page_write_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// EEPROM page-write sequencer core
// Command sequencer for a serial EEPROM with page-split writes and ack polling.
// ----------------------------------------------------------------------------
// Each accepted event item (read/write request, transaction done, service
// tick, bus refused) updates the controller state in the cycle it is taken
// and produces exactly one result item, which appears in the output register
// on the next cycle. One item is taken per clock; throughput is one item per
// cycle, limited only by the single output register: the input stalls only
// while a result is held there under output stall. Writes are cut into
// chunks of at most one page that stay within a page; after each chunk but the
// last, the device is polled on every tick until it acknowledges.
module eeprom_page_write_sequencer_core import epws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_READING = 3'd1,
    MODE_WRITING = 3'd2,
    MODE_WAITING = 3'd3,
    MODE_FAILED  = 3'd4
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [15:0]       addr_q, addr_d;
  logic [15:0]       left_q, left_d;
  logic [15:0]       offset_q, offset_d;
  logic [2:0]        chip_q, chip_d;
  logic [ChunkW-1:0] last_q, last_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, res;

  logic        accept;
  logic        do_chunk, fin, fin_ok, use_req;
  logic [15:0] src_left, src_addr, src_off;
  logic [2:0]  src_chip;
  logic        src_pend;
  chunk_t      chunk;

  // Handshake: output register frees up when empty or being taken
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Chunk source: the new request or the saved write progress
  assign src_left = use_req ? in_item_i.length      : left_q;
  assign src_addr = use_req ? in_item_i.mem_address : addr_q;
  assign src_off  = use_req ? 16'd0                 : offset_q;
  assign src_chip = use_req ? in_item_i.chip_select : chip_q;
  assign src_pend = use_req ? in_item_i.want_notify : pend_q;

  epws_chunk u_chunk (
    .bytes_left_i (src_left),
    .address_i    (src_addr),
    .chunk_o      (chunk)
  );

  // Event decode and next state
  always_comb begin
    mode_d   = mode_q;
    addr_d   = addr_q;
    left_d   = left_q;
    offset_d = offset_q;
    chip_d   = chip_q;
    last_d   = last_q;
    pend_d   = pend_q;
    res      = '0;
    do_chunk = 1'b0;
    fin      = 1'b0;
    fin_ok   = 1'b0;
    use_req  = 1'b0;

    unique case (in_item_i.func)
      FUNC_READ: begin
        if (mode_q == MODE_STOPPED) begin
          res.accepted    = 1'b1;
          mode_d          = MODE_READING;
          chip_d          = in_item_i.chip_select;
          pend_d          = in_item_i.want_notify;
          res.issue       = CMD_READ;
          res.device_byte = DevCmd | {5'd0, in_item_i.chip_select};
          res.trx_address = in_item_i.mem_address;
          res.trx_count   = in_item_i.length;
        end
      end
      FUNC_WRITE: begin
        if (mode_q == MODE_STOPPED && in_item_i.mem_address <= MaxWriteAddr) begin
          res.accepted = 1'b1;
          use_req      = 1'b1;
          do_chunk     = 1'b1;
          chip_d       = in_item_i.chip_select;
          addr_d       = in_item_i.mem_address;
          left_d       = in_item_i.length;
          offset_d     = 16'd0;
          pend_d       = in_item_i.want_notify;
        end
      end
      FUNC_DONE: begin
        if (mode_q != MODE_STOPPED) begin
          if (!in_item_i.trx_ok) begin
            // failed poll keeps waiting; anything else fails
            if (mode_q != MODE_WAITING) begin
              mode_d = MODE_FAILED;
              fin    = 1'b1;
            end
          end else begin
            unique case (mode_q)
              MODE_READING: begin
                mode_d = MODE_STOPPED;
                fin    = 1'b1;
                fin_ok = 1'b1;
              end
              MODE_WRITING: begin
                mode_d   = MODE_WAITING;
                do_chunk = (left_q == 16'd0);
              end
              MODE_WAITING: do_chunk = 1'b1;
              MODE_FAILED:  mode_d = MODE_STOPPED;
              default:      mode_d = MODE_FAILED;
            endcase
          end
        end
      end
      FUNC_TICK: begin
        if (mode_q == MODE_WAITING || mode_q == MODE_FAILED) begin
          res.issue       = CMD_POLL;
          res.device_byte = DevCmd | {5'd0, chip_q};
        end
      end
      FUNC_REFUSED: begin
        if (mode_q == MODE_READING) begin
          mode_d = MODE_STOPPED;
          fin    = 1'b1;
        end else if (mode_q == MODE_WRITING) begin
          // roll back the chunk the bus did not take
          left_d   = left_q + 16'(last_q);
          addr_d   = addr_q - 16'(last_q);
          offset_d = offset_q - 16'(last_q);
          mode_d   = MODE_FAILED;
          fin      = 1'b1;
        end
      end
      default: ;
    endcase

    // Issue next chunk or complete the write
    if (do_chunk) begin
      if (chunk.empty) begin
        mode_d = MODE_STOPPED;
        fin    = 1'b1;
        fin_ok = 1'b1;
      end else begin
        mode_d            = MODE_WRITING;
        res.issue         = CMD_WRITE;
        res.device_byte   = DevCmd | {5'd0, src_chip};
        res.trx_address   = src_addr;
        res.trx_count     = 16'(chunk.size);
        res.buffer_offset = src_off;
        last_d            = chunk.size;
        left_d            = src_left - 16'(chunk.size);
        addr_d            = src_addr + 16'(chunk.size);
        offset_d          = src_off + 16'(chunk.size);
      end
    end

    // Completion notice
    if (fin) begin
      if (src_pend) begin
        res.notify    = 1'b1;
        res.notify_ok = fin_ok;
      end
      pend_d = 1'b0;
    end

    res.ctrl_state = mode_d;
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STOPPED;
      addr_q      <= '0;
      left_q      <= '0;
      offset_q    <= '0;
      chip_q      <= '0;
      last_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        mode_q     <= mode_d;
        addr_q     <= addr_d;
        left_q     <= left_d;
        offset_q   <= offset_d;
        chip_q     <= chip_d;
        last_q     <= last_d;
        pend_q     <= pend_d;
        out_item_q <= res;
      end
    end
  end

`include "eeprom_page_write_sequencer_core_assert.svh"

  `EPWS_ASSERT_ALWAYS(a_stall_needs_result, !in_stall_o || out_valid_q, "stall without held result")
  `EPWS_ASSERT(a_chunk_size, !(out_valid_q && out_item_q.issue == CMD_WRITE) || (out_item_q.trx_count != 16'd0 && out_item_q.trx_count <= 16'(PageBytes)), "write chunk size out of range")
  `EPWS_ASSERT(a_poll_fields, !(out_valid_q && out_item_q.issue == CMD_POLL) || (out_item_q.trx_count == 16'd0 && out_item_q.trx_address == 16'd0), "poll carries address or count")
  `EPWS_ASSERT(a_notify_ok, !(out_valid_q && !out_item_q.notify) || !out_item_q.notify_ok, "notify_ok without notify")
  `EPWS_ASSERT(a_waiting_after_write, (accept && mode_q == MODE_WRITING && in_item_i.func == FUNC_DONE && in_item_i.trx_ok && left_q != 16'd0) |=> (mode_q == MODE_WAITING), "acked chunk did not enter polling")

endmodule

@@ tb/eeprom_page_write_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEPROM page-write sequencer core testbench
// Feeds event items (requests, transaction done, ticks, bus refusals) into
// the sequencer. A scoreboard keeps its own copy of the controller state,
// predicts the bus command and completion notice of each accepted item, and
// compares every result item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module eeprom_page_write_sequencer_core_tb;
  import epws_pkg::*;

  localparam int         ITEMS          = 1650;
  localparam int         PHASE_ITEMS    = 300;
  localparam int         HOLD_CYCLES    = 48;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         MAX_PRINTS     = 100;
  localparam logic [2:0] FUNC_RSVD      = 3'd7;

  // Controller modes as reported in ctrl_state
  typedef enum logic [2:0] {
    ST_STOPPED = 3'd0,
    ST_READING = 3'd1,
    ST_WRITING = 3'd2,
    ST_WAITING = 3'd3,
    ST_FAILED  = 3'd4
  } mode_e;

  // Shadow controller plus queue of predicted bus commands
  class epws_scoreboard;
    mode_e       mode;
    logic [15:0] wr_addr;
    logic [15:0] bytes_rem;
    logic [15:0] buf_off;
    logic [2:0]  sel_chip;
    logic [6:0]  chunk_len;
    logic        notice_due;
    out_item_t   cur;
    out_item_t   predicted_q[$];
    int unsigned errors;
    int unsigned results;

    function new();
      mode       = ST_STOPPED;
      wr_addr    = '0;
      bytes_rem  = '0;
      buf_off    = '0;
      sel_chip   = '0;
      chunk_len  = '0;
      notice_due = 1'b0;
      errors     = 0;
      results    = 0;
    endfunction

    function void close_op(logic ok);
      if (notice_due) begin
        cur.notify    = 1'b1;
        cur.notify_ok = ok;
      end
      notice_due = 1'b0;
    endfunction

    // Next page-bounded chunk, or completion when nothing is left
    function void issue_chunk();
      int n;
      int room;
      n = (bytes_rem > PageBytes) ? PageBytes : int'(bytes_rem);
      if (n == 0) begin
        mode = ST_STOPPED;
        close_op(1'b1);
        return;
      end
      room = PageBytes - int'(wr_addr % PageBytes);
      if (n > room) n = room;
      mode              = ST_WRITING;
      cur.issue         = CMD_WRITE;
      cur.device_byte   = DevCmd | {5'd0, sel_chip};
      cur.trx_address   = wr_addr;
      cur.trx_count     = 16'(n);
      cur.buffer_offset = buf_off;
      chunk_len         = 7'(n);
      bytes_rem         = bytes_rem - 16'(n);
      wr_addr           = wr_addr + 16'(n);
      buf_off           = buf_off + 16'(n);
    endfunction

    function void note_event(in_item_t it);
      cur = '0;
      case (it.func)
        FUNC_READ: begin
          if (mode == ST_STOPPED) begin
            cur.accepted    = 1'b1;
            mode            = ST_READING;
            sel_chip        = it.chip_select;
            notice_due      = it.want_notify;
            cur.issue       = CMD_READ;
            cur.device_byte = DevCmd | {5'd0, it.chip_select};
            cur.trx_address = it.mem_address;
            cur.trx_count   = it.length;
          end
        end
        FUNC_WRITE: begin
          if (mode == ST_STOPPED && it.mem_address <= MaxWriteAddr) begin
            cur.accepted = 1'b1;
            sel_chip     = it.chip_select;
            wr_addr      = it.mem_address;
            bytes_rem    = it.length;
            buf_off      = '0;
            notice_due   = it.want_notify;
            issue_chunk();
          end
        end
        FUNC_DONE: begin
          if (mode != ST_STOPPED) begin
            if (!it.trx_ok) begin
              // a failed poll keeps waiting
              if (mode != ST_WAITING) begin
                mode = ST_FAILED;
                close_op(1'b0);
              end
            end else begin
              case (mode)
                ST_READING: begin
                  mode = ST_STOPPED;
                  close_op(1'b1);
                end
                ST_WRITING: begin
                  mode = ST_WAITING;
                  if (bytes_rem == 0) issue_chunk();
                end
                ST_WAITING: issue_chunk();
                default: mode = ST_STOPPED;
              endcase
            end
          end
        end
        FUNC_TICK: begin
          if (mode == ST_WAITING || mode == ST_FAILED) begin
            cur.issue       = CMD_POLL;
            cur.device_byte = DevCmd | {5'd0, sel_chip};
          end
        end
        FUNC_REFUSED: begin
          if (mode == ST_READING) begin
            mode = ST_STOPPED;
            close_op(1'b0);
          end else if (mode == ST_WRITING) begin
            // roll back the chunk that never went out
            bytes_rem = bytes_rem + 16'(chunk_len);
            wr_addr   = wr_addr - 16'(chunk_len);
            buf_off   = buf_off - 16'(chunk_len);
            mode      = ST_FAILED;
            close_op(1'b0);
          end
        end
        default: ;
      endcase
      cur.ctrl_state = mode;
      predicted_q.push_back(cur);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got_v, logic [15:0] exp_v);
      if (got_v !== exp_v)
        report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                  results, name, got_v, exp_v));
    endtask

    task check_result(out_item_t got);
      out_item_t exp_r;
      if (predicted_q.size() == 0) begin
        report_mismatch("result item arrived with none expected");
        return;
      end
      exp_r = predicted_q.pop_front();
      check_field("accepted", 16'(got.accepted), 16'(exp_r.accepted));
      check_field("issue", 16'(got.issue), 16'(exp_r.issue));
      check_field("device_byte", 16'(got.device_byte), 16'(exp_r.device_byte));
      check_field("trx_address", got.trx_address, exp_r.trx_address);
      check_field("trx_count", got.trx_count, exp_r.trx_count);
      check_field("buffer_offset", got.buffer_offset, exp_r.buffer_offset);
      check_field("notify", 16'(got.notify), 16'(exp_r.notify));
      check_field("notify_ok", 16'(got.notify_ok), 16'(exp_r.notify_ok));
      check_field("ctrl_state", 16'(got.ctrl_state), 16'(exp_r.ctrl_state));
      results++;
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  epws_scoreboard sb = new();
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  sent;
  int  quiet_cycles;
  bit  hold_go;

  eeprom_page_write_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Watchdog: no item moving on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one event item and wait until it is taken
  task automatic post_event(input logic [2:0] f, input logic [2:0] cs,
                            input logic [15:0] a, input logic [15:0] l,
                            input logic w, input logic ok);
    in_item_t it;
    it.func        = f;
    it.chip_select = cs;
    it.mem_address = a;
    it.length      = l;
    it.want_notify = w;
    it.trx_ok      = ok;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(it);
    sent++;
  endtask

  // Control event with random filler in the unused fields
  task automatic post_ctl(input logic [2:0] f, input logic ok);
    post_event(f, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
               1'($urandom), ok);
  endtask

  task automatic post_random();
    post_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 16'($urandom),
               16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Request while busy, refused
  task automatic post_busy_req();
    post_event(3'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 16'($urandom),
               16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Drive the controller back to stopped
  task automatic settle();
    if (sb.mode == ST_FAILED) begin
      repeat ($urandom_range(0, 2)) post_ctl(FUNC_TICK, 1'($urandom));
      if ($urandom_range(0, 2) == 0) post_ctl(FUNC_DONE, 1'b0);
    end
    while (sb.mode != ST_STOPPED) begin
      if (sb.mode == ST_WRITING) post_ctl(FUNC_REFUSED, 1'($urandom));
      else post_ctl(FUNC_DONE, 1'b1);
    end
  endtask

  task automatic read_seq();
    int r;
    post_event(FUNC_READ, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
               1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) post_ctl(FUNC_TICK, 1'($urandom));
      else post_busy_req();
    end
    r = $urandom_range(0, 9);
    if (r < 6) post_ctl(FUNC_DONE, 1'b1);
    else if (r < 8) post_ctl(FUNC_DONE, 1'b0);
    else post_ctl(FUNC_REFUSED, 1'($urandom));
    settle();
  endtask

  task automatic write_seq();
    logic [15:0] addr;
    logic [15:0] len;
    int r;
    int steps;
    if ($urandom_range(0, 6) == 0) addr = 16'($urandom_range(16'h8000, 16'hFFFF));
    else addr = 16'($urandom_range(0, 16'h7FFF));
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r < 16) len = 16'($urandom_range(1, 200));
    else len = 16'($urandom_range(201, 1200));
    post_event(FUNC_WRITE, 3'($urandom_range(0, 7)), addr, len, 1'($urandom),
               1'($urandom));
    steps = 0;
    while ((sb.mode == ST_WRITING || sb.mode == ST_WAITING) && steps < 60) begin
      steps++;
      if (sb.mode == ST_WRITING) begin
        r = $urandom_range(0, 99);
        if (r < 88) post_ctl(FUNC_DONE, 1'b1);
        else if (r < 93) post_ctl(FUNC_DONE, 1'b0);
        else if (r < 97) post_ctl(FUNC_REFUSED, 1'($urandom));
        else if (r < 99) post_ctl(FUNC_TICK, 1'($urandom));
        else post_busy_req();
      end else begin
        // acknowledge polling, some polls unanswered
        repeat ($urandom_range(0, 2)) begin
          post_ctl(FUNC_TICK, 1'($urandom));
          if ($urandom_range(0, 2) == 0) post_ctl(FUNC_DONE, 1'b0);
        end
        post_ctl(FUNC_DONE, 1'b1);
      end
    end
    settle();
  endtask

  task automatic run_scenario();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) read_seq();
    else if (r < 8) write_seq();
    else begin
      repeat ($urandom_range(1, 4)) post_random();
      settle();
    end
  endtask

  // Full-length write that runs past the top of the address space
  task automatic long_write();
    int chunks;
    chunks  = 0;
    hold_go = 1'b1;
    post_event(FUNC_WRITE, 3'($urandom_range(0, 7)), 16'h7FC1, 16'hFFFF, 1'b1, 1'b0);
    while (!(sb.mode == ST_WRITING && sb.wr_addr != 0 && sb.wr_addr < 16'h7000)) begin
      post_ctl(FUNC_DONE, 1'b1);
      if (sb.mode == ST_WAITING) begin
        chunks++;
        if (chunks % 16 == 0) post_ctl(FUNC_TICK, 1'b1);
      end
    end
    post_ctl(FUNC_REFUSED, 1'b0);
    settle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    tx_idle_pct  = 18;
    rx_idle_pct  = 62;
    sent         = 0;
    quiet_cycles = 0;
    hold_go      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Read path, busy refusal, ignored events
    post_event(FUNC_READ, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    post_event(FUNC_WRITE, 3'd1, 16'h0000, 16'h0004, 1'b1, 1'b0);
    post_event(FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_DONE, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    post_event(FUNC_RSVD, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    post_event(FUNC_REFUSED, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // Write address out of range, empty write
    post_event(FUNC_WRITE, 3'd3, 16'h8000, 16'h0005, 1'b1, 1'b0);
    post_event(FUNC_WRITE, 3'd3, 16'hFFFF, 16'h0005, 1'b1, 1'b0);
    post_event(FUNC_WRITE, 3'd4, 16'h0000, 16'h0000, 1'b1, 1'b0);
    // Last byte of the page, polling, refusal rollback, failed state
    post_event(FUNC_WRITE, 3'd5, 16'h7FFF, 16'h0003, 1'b1, 1'b0);
    post_event(FUNC_READ, 3'd2, 16'h1234, 16'h0010, 1'b1, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_REFUSED, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    // Failed read without notice, refused read with notice
    post_event(FUNC_READ, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_READ, 3'd3, 16'h00FF, 16'h0100, 1'b1, 1'b0);
    post_event(FUNC_REFUSED, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // Two chunks, last one completes without polling
    post_event(FUNC_WRITE, 3'd6, 16'h0010, 16'h0050, 1'b1, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    // Whole page, chunk transaction fails
    post_event(FUNC_WRITE, 3'd2, 16'h7FC0, 16'h0040, 1'b1, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    post_event(FUNC_DONE, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);

    // Random sequences under three idling profiles
    while (sent < PHASE_ITEMS) run_scenario();
    tx_idle_pct = 62;
    rx_idle_pct = 18;
    while (sent < 2 * PHASE_ITEMS) run_scenario();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_write();
    while (sent < ITEMS) run_scenario();
    in_valid_i <= 1'b0;

    while (sb.predicted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/epws_pkg.sv
src/epws_chunk.sv
src/eeprom_page_write_sequencer_core.sv
tb/eeprom_page_write_sequencer_core_tb.sv
